FILE: hdl/dmacr_pkg.sv
// Shared types and constants for the DMA controller register block.
package dmacr_pkg;
  localparam int NumChan = 8;
  localparam int ChanW = 3;

  typedef enum logic [1:0] {
    CMD_IO_RD = 2'd0,
    CMD_IO_WR = 2'd1,
    CMD_DMA_RD = 2'd2,
    CMD_DMA_WR = 2'd3
  } cmd_t;

  localparam logic [1:0] MEM_NONE = 2'd0;
  localparam logic [1:0] MEM_RD = 2'd1;
  localparam logic [1:0] MEM_WR = 2'd2;

  localparam logic [3:0] REG_STATUS = 4'h8;
  localparam logic [3:0] REG_REQUEST = 4'h9;
  localparam logic [3:0] REG_MASK = 4'hA;
  localparam logic [3:0] REG_MODE = 4'hB;
  localparam logic [3:0] REG_CLR_FF = 4'hC;
  localparam logic [3:0] REG_MASTER_CLR = 4'hD;
  localparam logic [3:0] REG_ALL_MASK = 4'hF;

  localparam logic [7:0] STATUS_VAL = 8'h0F;
  localparam logic [7:0] UNUSED_VAL = 8'hFF;

  typedef struct packed {
    logic       load;
    logic [1:0] cmd;
    logic [7:0] port;
    logic [7:0] data;
    logic [2:0] chan;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  mem_op;
    logic [23:0] mem_address;
    logic [7:0]  mem_data;
  } dp_res_t;

  // page port nibble to channel; valid bit high when a channel is mapped
  function automatic logic [3:0] page_map(input logic [3:0] nib);
    logic [3:0] r;
    case (nib)
      4'h1: r = 4'b1010;
      4'h2: r = 4'b1011;
      4'h3: r = 4'b1001;
      4'h7: r = 4'b1000;
      4'h9: r = 4'b1110;
      4'hA: r = 4'b1111;
      4'hB: r = 4'b1101;
      4'hF: r = 4'b1100;
      default: r = 4'b0000;
    endcase
    return r;
  endfunction
endpackage

FILE: hdl/dma_controller_registers_core.sv
// Top level of the eight-channel DMA controller register block.
// Input channel: in_valid/in_stall carry one word (command, port, write_data,
// channel): an I/O read or write, or one DMA read or write step.
// Output channel: out_valid/out_stall carry one result word per input word:
// read_data, mem_op, mem_address, mem_data.
// The result is registered at the edge that accepts the word. Throughput is
// one word per cycle while the receiver does not stall; the single output
// register is refilled in the same cycle that it is taken.
// When the receiver stalls, the result holds and in_stall rises until it is
// taken. Reset clears all channel registers, masks every channel and empties
// the output register; a master-clear write does the same to the registers.
module dma_controller_registers_core
  import dmacr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  port,
  input  logic [7:0]  write_data,
  input  logic [2:0]  channel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [1:0]  mem_op,
  output logic [23:0] mem_address,
  output logic [7:0]  mem_data
);
  dp_cmd_t ctl;
  dp_res_t res;

  dmacr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .cmd(command), .port(port), .data(write_data), .chan(channel),
    .out_valid(out_valid), .out_stall(out_stall), .ctl(ctl)
  );

  dmacr_datapath u_dp (.clk(clk), .rst(rst), .ctl(ctl), .res(res));

  assign read_data = res.read_data;
  assign mem_op = res.mem_op;
  assign mem_address = res.mem_address;
  assign mem_data = res.mem_data;
endmodule

FILE: hdl/dmacr_datapath.sv
// Register file and DMA address/count update datapath.
module dmacr_datapath
  import dmacr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  dp_cmd_t ctl,
  output dp_res_t res
);
  logic        byte_pointer;
  logic        mem_to_mem_mode;
  logic [7:0]  spare_page_bytes [16];
  logic [NumChan-1:0] chan_masked, chan_auto_init, chan_request, chan_decrement;
  logic [1:0]  chan_operation [NumChan];
  logic [1:0]  chan_mode [NumChan];
  logic [15:0] chan_address [NumChan];
  logic [15:0] chan_count [NumChan];
  logic [15:0] chan_base_address [NumChan];
  logic [15:0] chan_base_count [NumChan];
  logic [7:0]  chan_page [NumChan];

  logic [3:0]  idx;
  logic        is_page, is_hi;
  logic [3:0]  pm;
  logic [ChanW-1:0] rc, dc, wc;
  logic [15:0] rv, wv, na, nc;
  dp_res_t     r_next;

  always_comb begin
    is_hi = ctl.port >= 8'hC0;
    is_page = !is_hi && ctl.port >= 8'h80;
    idx = is_hi ? {1'b0, ctl.port[3:1]} : ctl.port[3:0];
    pm = page_map(ctl.port[3:0]);
    rc = {1'b0, idx[2:1]};
    dc = ctl.data[ChanW-1:0];
    wc = ctl.chan;
    rv = idx[0] ? chan_count[rc] : chan_address[rc];
    wv = byte_pointer ? {ctl.data, rv[7:0]} : {rv[15:8], ctl.data};
    na = chan_decrement[wc] ? chan_address[wc] - 16'd1 : chan_address[wc] + 16'd1;
    nc = chan_count[wc] - 16'd1;
    r_next = '0;
    unique case (cmd_t'(ctl.cmd))
      CMD_IO_RD: begin
        if (is_page) begin
          r_next.read_data = pm[3] ? chan_page[pm[2:0]] : spare_page_bytes[ctl.port[3:0]];
        end else if (!idx[3]) begin
          r_next.read_data = byte_pointer ? rv[15:8] : rv[7:0];
        end else if (idx == REG_STATUS) begin
          r_next.read_data = STATUS_VAL;
        end else begin
          r_next.read_data = UNUSED_VAL;
        end
      end
      CMD_IO_WR: ;
      CMD_DMA_RD, CMD_DMA_WR: begin
        r_next.mem_op = (ctl.cmd == CMD_DMA_RD) ? MEM_RD : MEM_WR;
        r_next.mem_address = {chan_page[wc], chan_address[wc]};
        r_next.mem_data = (ctl.cmd == CMD_DMA_WR) ? ctl.data : 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) res <= r_next;
    if (rst || (ctl.load && ctl.cmd == CMD_IO_WR && !is_page && idx == REG_MASTER_CLR)) begin
      byte_pointer <= 1'b0;
      mem_to_mem_mode <= 1'b0;
      chan_masked <= '1;
      chan_auto_init <= '0;
      chan_request <= '0;
      chan_decrement <= '0;
      for (int i = 0; i < 16; i++) spare_page_bytes[i] <= '0;
      for (int i = 0; i < NumChan; i++) begin
        chan_operation[i] <= '0;
        chan_mode[i] <= '0;
        chan_address[i] <= '0;
        chan_count[i] <= '0;
        chan_base_address[i] <= '0;
        chan_base_count[i] <= '0;
        chan_page[i] <= '0;
      end
    end else if (ctl.load) begin
      case (cmd_t'(ctl.cmd))
        CMD_IO_RD: begin
          if (!is_page && !idx[3]) byte_pointer <= ~byte_pointer;
        end
        CMD_IO_WR: begin
          if (is_page) begin
            if (pm[3]) chan_page[pm[2:0]] <= ctl.data;
            else spare_page_bytes[ctl.port[3:0]] <= ctl.data;
          end else if (!idx[3]) begin
            byte_pointer <= ~byte_pointer;
            if (idx[0]) begin
              chan_count[rc] <= wv;
              chan_base_count[rc] <= wv;
            end else begin
              chan_address[rc] <= wv;
              chan_base_address[rc] <= wv;
            end
          end else begin
            case (idx)
              REG_STATUS: mem_to_mem_mode <= ctl.data[0];
              REG_REQUEST: chan_request[dc] <= ctl.data[2];
              REG_MASK: chan_masked[dc] <= ctl.data[2];
              REG_MODE: begin
                chan_operation[dc] <= ctl.data[3:2];
                chan_auto_init[dc] <= ctl.data[4];
                chan_decrement[dc] <= ctl.data[5];
                chan_mode[dc] <= ctl.data[7:6];
              end
              REG_CLR_FF: byte_pointer <= 1'b0;
              REG_ALL_MASK: chan_masked <= ctl.data;
              default: ;
            endcase
          end
        end
        default: begin
          if (nc == 16'hFFFF && chan_auto_init[wc]) begin
            chan_count[wc] <= chan_base_count[wc];
            chan_address[wc] <= chan_base_address[wc];
          end else begin
            chan_count[wc] <= nc;
            chan_address[wc] <= na;
          end
        end
      endcase
    end
  end
endmodule

FILE: hdl/dmacr_ctrl.sv
// Handshake controller: takes one word, holds the result until taken.
module dmacr_ctrl
  import dmacr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] port,
  input  logic [7:0] data,
  input  logic [2:0] chan,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    ctl
);
  typedef enum logic {S_EMPTY, S_FULL} state_t;
  state_t state;

  assign in_stall = (state == S_FULL) && out_stall;
  assign out_valid = (state == S_FULL);

  always_comb begin
    ctl.load = in_valid && !in_stall;
    ctl.cmd = cmd;
    ctl.port = port;
    ctl.data = data;
    ctl.chan = chan;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EMPTY;
    end else begin
      unique case (state)
        S_EMPTY: if (ctl.load) state <= S_FULL;
        S_FULL: if (!out_stall && !ctl.load) state <= S_EMPTY;
      endcase
    end
  end
endmodule
